@@ rtl/gaca_pkg.sv @@
// ----------------------------------------------------------------------------
// gaca_pkg
// Shared constants, types and codes of the glyph atlas column allocator.
// ----------------------------------------------------------------------------
package gaca_pkg;

  localparam int ATLAS_PIXELS = 1024;
  localparam int MAX_ATLASES  = 4;
  localparam int MAX_COLUMNS  = 32;
  localparam int NUM_CELLS    = MAX_ATLASES * MAX_COLUMNS;

  // Pixel quantities inside an atlas run from 0 to ATLAS_PIXELS.
  localparam int PIX_W = $clog2(ATLAS_PIXELS) + 1;
  localparam int AT_W  = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  // Fixed field widths of the ports.
  localparam int GW_W   = 11;
  localparam int BW_W   = 4;
  localparam int THR_W  = 11;
  localparam int AIDX_W = 2;
  localparam int RPOS_W = 10;
  localparam int PAD_W  = (GW_W + 1 > PIX_W) ? GW_W + 1 : PIX_W;
  localparam int CMP_W  = (PIX_W > THR_W) ? PIX_W : THR_W;

  localparam int S_DATA_W   = 24;
  localparam int S_USER_W   = 2;
  localparam int M_FIELDS_W = AIDX_W + 2 * RPOS_W + 2 * GW_W + 1;
  localparam int M_DATA_W   = 48;
  localparam int M_USER_W   = 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [PIX_W-1:0] PIX_FULL = PIX_W'(ATLAS_PIXELS);
  localparam logic [PAD_W-1:0] PAD_FULL = PAD_W'(ATLAS_PIXELS);

  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

  localparam logic [BW_W-1:0]  BORDER_RESET = 4'd1;
  localparam logic [THR_W-1:0] THRESH_RESET = 11'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // Search record that walks down the column cells.
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] colx;
    logic             exact;
    logic [AT_W-1:0]  ex_atlas;
    logic [COL_W-1:0] ex_col;
    logic [PIX_W-1:0] ex_x;
    logic [PIX_W-1:0] ex_hl;
    logic             found;
    logic [PIX_W-1:0] best_diff;
    logic [AT_W-1:0]  best_atlas;
    logic [COL_W-1:0] best_col;
    logic [PIX_W-1:0] best_x;
    logic [PIX_W-1:0] best_hl;
  } scan_rec_t;

  typedef struct packed {
    logic [PIX_W-1:0] pw;
    logic [PIX_W-1:0] ph;
  } scan_req_t;

  typedef struct packed {
    logic             en;
    logic             new_col;
    logic [AT_W-1:0]  atlas;
    logic [COL_W-1:0] col;
  } col_wr_t;

endpackage

@@ rtl/glyph_atlas_column_allocator.sv @@
// ----------------------------------------------------------------------------
// glyph_atlas_column_allocator
// Places glyph rectangles into column-split atlases.
//
//   Channel  Signals                                   Beat carries
//   s_       s_tvalid s_tready s_tdata s_tuser         one request
//   m_       m_tvalid m_tready m_tdata m_tuser         one result
//   cfg_     cfg_valid cfg_ready cfg_index cfg_data    one register write
//
// A placement steps through launch, the search chain (one registered cell per
// column cell, MAX_ATLASES * MAX_COLUMNS cells), the decision, the result load
// and the return to idle for the next request. The result load waits while m_
// still holds a result. Flush and oversized requests skip the search.
// One request is in work at a time; a new one is taken while the last
// result still waits on m_. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module glyph_atlas_column_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gaca_pkg::S_DATA_W-1:0]      s_tdata,  // glyph_width, glyph_height
  input  logic [gaca_pkg::S_USER_W-1:0]      s_tuser,  // kind, in_color
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // atlas_index, rect_x, rect_y, rect_w, rect_h, new_atlas
  output logic [gaca_pkg::M_DATA_W-1:0]      m_tdata,
  output logic [gaca_pkg::M_USER_W-1:0]      m_tuser,  // status
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gaca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gaca_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gaca_pkg::*;

  logic [MAX_ATLASES-1:0]            scan_en;
  logic [MAX_ATLASES-1:0][CNT_W-1:0] col_count;
  scan_req_t                         req;
  col_wr_t                           wr;
  scan_rec_t                         chain [NUM_CELLS+1];

  gaca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan_en   (scan_en),
    .col_count (col_count),
    .req       (req),
    .wr        (wr),
    .head      (chain[0]),
    .tail      (chain[NUM_CELLS])
  );

  // Cells run in scan order: atlas by atlas, column by column.
  for (genvar ga = 0; ga < MAX_ATLASES; ga++) begin : g_atlas
    for (genvar gc = 0; gc < MAX_COLUMNS; gc++) begin : g_col
      gaca_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cell_atlas  (AT_W'(ga)),
        .cell_col    (COL_W'(gc)),
        .atlas_match (scan_en[ga]),
        .col_count   (col_count[ga]),
        .req         (req),
        .wr          (wr),
        .rec_in      (chain[ga*MAX_COLUMNS+gc]),
        .rec_out     (chain[ga*MAX_COLUMNS+gc+1])
      );
    end
  end

endmodule

@@ rtl/gaca_cell.sv @@
// ----------------------------------------------------------------------------
// gaca_cell
// One column slot: holds its width and height left, updates the passing
// search record and registers it for the next cell.
// ----------------------------------------------------------------------------
module gaca_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gaca_pkg::AT_W-1:0]  cell_atlas,
  input  logic [gaca_pkg::COL_W-1:0] cell_col,
  input  logic                      atlas_match,
  input  logic [gaca_pkg::CNT_W-1:0] col_count,
  input  gaca_pkg::scan_req_t        req,
  input  gaca_pkg::col_wr_t          wr,
  input  gaca_pkg::scan_rec_t        rec_in,
  output gaca_pkg::scan_rec_t        rec_out
);
  import gaca_pkg::*;

  logic [PIX_W-1:0] col_w;
  logic [PIX_W-1:0] col_hl;
  logic             live;
  logic             fits;
  logic [PIX_W-1:0] colx_base;
  logic [PIX_W-1:0] diff;
  scan_rec_t        rec_next;

  always_comb begin
    live      = atlas_match && (CNT_W'(cell_col) < col_count);
    // Column positions restart at the first slot of every atlas.
    colx_base = (cell_col == '0) ? '0 : rec_in.colx;
    diff      = col_w - req.pw;
    fits      = live && !rec_in.exact && (col_w >= req.pw) && (col_hl >= req.ph);
    rec_next  = rec_in;
    rec_next.colx = live ? PIX_W'(colx_base + col_w) : colx_base;
    if (fits) begin
      if (diff == '0) begin
        rec_next.exact    = 1'b1;
        rec_next.ex_atlas = cell_atlas;
        rec_next.ex_col   = cell_col;
        rec_next.ex_x     = colx_base;
        rec_next.ex_hl    = col_hl;
      end else if (!rec_in.found || diff < rec_in.best_diff) begin
        rec_next.found      = 1'b1;
        rec_next.best_diff  = diff;
        rec_next.best_atlas = cell_atlas;
        rec_next.best_col   = cell_col;
        rec_next.best_x     = colx_base;
        rec_next.best_hl    = col_hl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out <= '0;
    end else begin
      rec_out <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.atlas == cell_atlas && wr.col == cell_col) begin
      if (wr.new_col) begin
        col_w  <= req.pw;
        col_hl <= PIX_FULL - req.ph;
      end else begin
        col_hl <= col_hl - req.ph;
      end
    end
  end

endmodule

@@ rtl/gaca_ctrl.sv @@
// ----------------------------------------------------------------------------
// gaca_ctrl
// Request sequencer: atlas table, configuration, placement decision and the
// output register.
// ----------------------------------------------------------------------------
module gaca_ctrl (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  input  logic [gaca_pkg::S_DATA_W-1:0]                    s_tdata,
  input  logic [gaca_pkg::S_USER_W-1:0]                    s_tuser,
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  output logic [gaca_pkg::M_DATA_W-1:0]                    m_tdata,
  output logic [gaca_pkg::M_USER_W-1:0]                    m_tuser,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [gaca_pkg::CFG_IDX_W-1:0]                   cfg_index,
  input  logic [gaca_pkg::CFG_DATA_W-1:0]                  cfg_data,
  output logic [gaca_pkg::MAX_ATLASES-1:0]                 scan_en,
  output logic [gaca_pkg::MAX_ATLASES-1:0][gaca_pkg::CNT_W-1:0] col_count,
  output gaca_pkg::scan_req_t                              req,
  output gaca_pkg::col_wr_t                                wr,
  output gaca_pkg::scan_rec_t                              head,
  input  gaca_pkg::scan_rec_t                              tail
);
  import gaca_pkg::*;

  state_t state;
  state_t state_next;

  logic [BW_W-1:0]  border;
  logic [THR_W-1:0] thresh;

  logic [MAX_ATLASES-1:0]            used;
  logic [MAX_ATLASES-1:0]            colour;
  logic [MAX_ATLASES-1:0][PIX_W-1:0] width_left;
  logic [MAX_ATLASES-1:0][CNT_W-1:0] count;

  logic [GW_W-1:0]  req_gw;
  logic [GW_W-1:0]  req_gh;
  logic             req_color;
  logic [BW_W-1:0]  req_bw;
  logic             launch;
  scan_rec_t        tail_q;

  logic             pend_status;
  logic [AIDX_W-1:0] pend_atlas;
  logic [RPOS_W-1:0] pend_x;
  logic [RPOS_W-1:0] pend_y;
  logic [GW_W-1:0]  pend_w;
  logic [GW_W-1:0]  pend_h;
  logic             pend_new;

  logic             s_accept;
  logic             in_kind;
  logic             in_color;
  logic [GW_W-1:0]  in_gw;
  logic [GW_W-1:0]  in_gh;
  logic [PAD_W-1:0] pad_w;
  logic [PAD_W-1:0] pad_h;
  logic             too_big;
  logic             out_load;

  logic             dec_ok;
  logic             dec_newcol;
  logic             dec_newatlas;
  logic [AT_W-1:0]  dec_atlas;
  logic [COL_W-1:0] dec_col;
  logic [PIX_W-1:0] dec_x;
  logic [PIX_W-1:0] dec_hl;
  logic [PIX_W:0]   pos_x;
  logic [PIX_W:0]   pos_y;

  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign in_kind   = s_tuser[0];
  assign in_color  = s_tuser[1];
  assign in_gw     = s_tdata[GW_W-1:0];
  assign in_gh     = s_tdata[2*GW_W-1:GW_W];
  assign pad_w     = PAD_W'(in_gw) + (PAD_W'(border) << 1);
  assign pad_h     = PAD_W'(in_gh) + (PAD_W'(border) << 1);
  assign too_big   = (pad_w > PAD_FULL) || (pad_h > PAD_FULL);
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);

  assign col_count = count;
  always_comb begin
    for (int a = 0; a < MAX_ATLASES; a++) begin
      scan_en[a] = used[a] && (colour[a] == req_color);
    end
    head       = '0;
    head.valid = launch;
  end

  // Placement choice once the search record has left the last cell.
  always_comb begin
    logic nc_hit;
    logic na_hit;
    dec_ok       = 1'b0;
    dec_newcol   = 1'b0;
    dec_newatlas = 1'b0;
    dec_atlas    = '0;
    dec_col      = '0;
    dec_x        = '0;
    dec_hl       = PIX_FULL;
    nc_hit       = 1'b0;
    na_hit       = 1'b0;
    if (tail_q.exact) begin
      dec_ok    = 1'b1;
      dec_atlas = tail_q.ex_atlas;
      dec_col   = tail_q.ex_col;
      dec_x     = tail_q.ex_x;
      dec_hl    = tail_q.ex_hl;
    end else if (tail_q.found && CMP_W'(tail_q.best_diff) <= CMP_W'(thresh)) begin
      dec_ok    = 1'b1;
      dec_atlas = tail_q.best_atlas;
      dec_col   = tail_q.best_col;
      dec_x     = tail_q.best_x;
      dec_hl    = tail_q.best_hl;
    end else begin
      for (int a = 0; a < MAX_ATLASES; a++) begin
        if (!nc_hit && used[a] && colour[a] == req_color && width_left[a] >= req.pw &&
            count[a] < CNT_W'(MAX_COLUMNS)) begin
          nc_hit    = 1'b1;
          dec_atlas = AT_W'(a);
          dec_col   = COL_W'(count[a]);
          dec_x     = PIX_FULL - width_left[a];
        end
      end
      if (!nc_hit) begin
        for (int a = 0; a < MAX_ATLASES; a++) begin
          if (!na_hit && !used[a]) begin
            na_hit    = 1'b1;
            dec_atlas = AT_W'(a);
          end
        end
      end
      dec_ok       = nc_hit || na_hit;
      dec_newcol   = nc_hit || na_hit;
      dec_newatlas = !nc_hit && na_hit;
    end
    pos_x = (PIX_W + 1)'(dec_x) + (PIX_W + 1)'(req_bw);
    pos_y = (PIX_W + 1)'(PIX_FULL - dec_hl) + (PIX_W + 1)'(req_bw);
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    wr         = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_accept) begin
          state_next = (in_kind == KIND_FLUSH || too_big) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        wr.en      = dec_ok;
        wr.new_col = dec_newcol;
        wr.atlas   = dec_atlas;
        wr.col     = dec_col;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      border <= BORDER_RESET;
      thresh <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BORDER: border <= cfg_data[BW_W-1:0];
        REG_THRESH: thresh <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      colour <= '0;
      count  <= '0;
      launch <= 1'b0;
    end else begin
      launch <= s_accept && in_kind == KIND_PLACE && !too_big;
      if (s_accept && in_kind == KIND_FLUSH) begin
        used   <= '0;
        colour <= '0;
        count  <= '0;
      end else if (state == ST_DECIDE && dec_newcol) begin
        if (dec_newatlas) begin
          used[dec_atlas]   <= 1'b1;
          colour[dec_atlas] <= req_color;
          count[dec_atlas]  <= CNT_W'(1);
        end else begin
          count[dec_atlas]  <= count[dec_atlas] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && dec_newcol) begin
      if (dec_newatlas) begin
        width_left[dec_atlas] <= PIX_FULL - req.pw;
      end else begin
        width_left[dec_atlas] <= width_left[dec_atlas] - req.pw;
      end
    end
    if (state == ST_SCAN && tail.valid) begin
      tail_q <= tail;
    end
    if (s_accept) begin
      req_gw    <= in_gw;
      req_gh    <= in_gh;
      req_color <= in_color;
      req_bw    <= border;
      req.pw    <= PIX_W'(pad_w);
      req.ph    <= PIX_W'(pad_h);
      pend_status <= (in_kind == KIND_PLACE && too_big) ? STATUS_FAIL : STATUS_OK;
      pend_atlas  <= '0;
      pend_x      <= '0;
      pend_y      <= '0;
      pend_w      <= '0;
      pend_h      <= '0;
      pend_new    <= 1'b0;
    end else if (state == ST_DECIDE) begin
      pend_status <= dec_ok ? STATUS_OK : STATUS_FAIL;
      pend_atlas  <= dec_ok ? AIDX_W'(dec_atlas) : '0;
      pend_x      <= dec_ok ? pos_x[RPOS_W-1:0] : '0;
      pend_y      <= dec_ok ? pos_y[RPOS_W-1:0] : '0;
      pend_w      <= dec_ok ? req_gw : '0;
      pend_h      <= dec_ok ? req_gh : '0;
      pend_new    <= dec_newatlas;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(M_DATA_W - M_FIELDS_W)'(0), pend_new, pend_h, pend_w, pend_y, pend_x,
                  pend_atlas};
      m_tuser <= pend_status;
    end
  end

`ifndef NO_ASSERTIONS
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == ST_SCAN)
    else $error("search record left the chain outside of a scan");

  a_write_then_done: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> state == ST_DONE && !wr.en)
    else $error("column write not followed by result hand-off");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == ST_IDLE)
    else $error("result not presented after load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == ST_SCAN && !s_tready)
    else $error("scan launched outside of a scan");
`endif

endmodule

@@ tb/tb_glyph_atlas_column_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_glyph_atlas_column_allocator
// Drives requests into the allocator and checks every result beat against a
// behavioral allocator kept in the testbench. It runs directed corner cases,
// then random bursts and a receiver hold under several border and threshold settings.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_column_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import gaca_pkg::*;

  localparam int STALL_LIMIT = 20000;

  // Laid out like {m_tuser, m_tdata}, last field in the lowest bits.
  typedef struct packed {
    logic       status;
    logic       fresh;
    logic [10:0] h;
    logic [10:0] w;
    logic [9:0] y;
    logic [9:0] x;
    logic [1:0] atlas;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  glyph_atlas_column_allocator dut (.*);

  always #2 clk = ~clk;

  // Predictor state.
  int unsigned border_px, fit_limit;
  bit atlas_open [MAX_ATLASES];
  bit atlas_rgb [MAX_ATLASES];
  int unsigned atlas_room [MAX_ATLASES];
  int unsigned atlas_cols [MAX_ATLASES];
  int unsigned col_w [NUM_CELLS];
  int unsigned col_room [NUM_CELLS];

  placement_t pending_q[$];
  bit failed = 1'b0;
  bit sink_hold = 1'b0;
  bit calm = 1'b0;
  int idle_cycles = 0;

  function automatic placement_t take_column(int unsigned a, int unsigned idx,
                                             int unsigned colx, int unsigned gw,
                                             int unsigned gh, int unsigned ph,
                                             bit fresh);
    placement_t r;
    r.status = STATUS_OK;
    r.atlas = a[1:0];
    r.x = 10'(colx + border_px);
    r.y = 10'(ATLAS_PIXELS - col_room[idx] + border_px);
    r.w = gw[10:0];
    r.h = gh[10:0];
    r.fresh = fresh;
    col_room[idx] -= ph;
    return r;
  endfunction

  function automatic placement_t allocate(bit kind, int unsigned gw, int unsigned gh,
                                          bit rgb);
    placement_t r;
    int unsigned pw, ph, colx, idx, cw, best_diff, best_a, best_idx, best_x;
    bit found;
    r = '0;
    found = 0;
    best_diff = 0; best_a = 0; best_idx = 0; best_x = 0;
    if (kind == KIND_FLUSH) begin
      foreach (atlas_open[a]) begin
        atlas_open[a] = 0; atlas_rgb[a] = 0; atlas_cols[a] = 0;
      end
      return r;
    end
    pw = gw + 2 * border_px;
    ph = gh + 2 * border_px;
    r.status = STATUS_FAIL;
    if (pw > ATLAS_PIXELS || ph > ATLAS_PIXELS) return r;
    for (int a = 0; a < MAX_ATLASES; a++) begin
      if (!atlas_open[a] || atlas_rgb[a] != rgb) continue;
      colx = 0;
      for (int c = 0; c < atlas_cols[a]; c++) begin
        idx = a * MAX_COLUMNS + c;
        cw = col_w[idx];
        if (cw >= pw && col_room[idx] >= ph) begin
          if (cw == pw) return take_column(a, idx, colx, gw, gh, ph, 0);
          if (!found || cw - pw < best_diff) begin
            found = 1; best_diff = cw - pw; best_a = a; best_idx = idx; best_x = colx;
          end
        end
        colx += cw;
      end
    end
    if (found && best_diff <= fit_limit)
      return take_column(best_a, best_idx, best_x, gw, gh, ph, 0);
    for (int a = 0; a < MAX_ATLASES; a++) begin
      if (atlas_open[a] && atlas_rgb[a] == rgb && atlas_room[a] >= pw &&
          atlas_cols[a] < MAX_COLUMNS) begin
        idx = a * MAX_COLUMNS + atlas_cols[a];
        colx = ATLAS_PIXELS - atlas_room[a];
        atlas_room[a] -= pw;
        atlas_cols[a]++;
        col_w[idx] = pw;
        col_room[idx] = ATLAS_PIXELS;
        return take_column(a, idx, colx, gw, gh, ph, 0);
      end
    end
    for (int a = 0; a < MAX_ATLASES; a++) begin
      if (!atlas_open[a]) begin
        idx = a * MAX_COLUMNS;
        atlas_open[a] = 1; atlas_rgb[a] = rgb;
        atlas_room[a] = ATLAS_PIXELS - pw;
        atlas_cols[a] = 1;
        col_w[idx] = pw;
        col_room[idx] = ATLAS_PIXELS;
        return take_column(a, idx, 0, gw, gh, ph, 1);
      end
    end
    return r;
  endfunction

  // Result checker and receiver backpressure.
  always @(posedge clk) begin
    placement_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[M_FIELDS_W-1:0]};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          failed = 1'b1;
        end
        if (got.atlas !== want.atlas) begin
          $display("%0t: atlas exp %0d got %0d", $time, want.atlas, got.atlas);
          failed = 1'b1;
        end
        if (got.x !== want.x) begin
          $display("%0t: rect_x exp %0d got %0d", $time, want.x, got.x);
          failed = 1'b1;
        end
        if (got.y !== want.y) begin
          $display("%0t: rect_y exp %0d got %0d", $time, want.y, got.y);
          failed = 1'b1;
        end
        if (got.w !== want.w) begin
          $display("%0t: rect_w exp %0d got %0d", $time, want.w, got.w);
          failed = 1'b1;
        end
        if (got.h !== want.h) begin
          $display("%0t: rect_h exp %0d got %0d", $time, want.h, got.h);
          failed = 1'b1;
        end
        if (got.fresh !== want.fresh) begin
          $display("%0t: new_atlas exp %0d got %0d", $time, want.fresh, got.fresh);
          failed = 1'b1;
        end
      end
    end
  end

  always @(negedge clk)
    m_tready <= !sink_hold && (calm || $urandom_range(99) >= 16);

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL glyph_atlas_column_allocator");
      $finish;
    end
  end

  // Starts and ends on a falling edge; the beat stays up until the next one
  // or until drain() drops it.
  task automatic send_request(bit kind, int unsigned gw, int unsigned gh, bit rgb);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b0, gh[10:0], gw[10:0]};
    s_tuser <= {rgb, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_q = {pending_q, allocate(kind, gw, gh, rgb)};
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_BORDER) border_px = value & 15;
    else fit_limit = value & 11'h7FF;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_corners();
    send_request(KIND_PLACE, 0, 0, 0);
    send_request(KIND_PLACE, 1024, 10, 0);      // too wide once padded, unless border is 0
    send_request(KIND_PLACE, 10, 1022, 1);
    send_request(KIND_PLACE, 1022, 1022, 1);
    send_request(KIND_PLACE, 2047, 2047, 0);
    send_request(KIND_PLACE, 10, 20, 0);
    send_request(KIND_PLACE, 10, 20, 0);        // exact column fit
    send_request(KIND_PLACE, 8, 5, 0);          // best fit in wider column
    send_request(KIND_PLACE, 500, 900, 1);
    send_request(KIND_PLACE, 500, 900, 0);
    send_request(KIND_PLACE, 500, 900, 0);
    send_request(KIND_FLUSH, 2047, 2047, 1);
    for (int i = 0; i < 36; i++)                // fills one atlas's columns, spills over; too tall if border > 1
      send_request(KIND_PLACE, 0, 1022, 0);
    send_request(KIND_FLUSH, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(int n);
    int unsigned gw, gh;
    bit rgb, kind;
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(99) < 2);
      rgb = $urandom_range(1);
      case ($urandom_range(9))
        0: begin gw = $urandom_range(2047); gh = $urandom_range(2047); end
        1: begin gw = $urandom_range(1024); gh = $urandom_range(1024); end
        2, 3: begin gw = $urandom_range(200); gh = $urandom_range(400); end
        default: begin gw = $urandom_range(40); gh = $urandom_range(60); end
      endcase
      send_request(kind, gw, gh, rgb);
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (600) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_request(KIND_PLACE, i * 3, 7, 1);
    join
    drain();
  endtask

  initial begin
    border_px = BORDER_RESET;
    fit_limit = THRESH_RESET;
    foreach (atlas_open[a]) begin
      atlas_open[a] = 0; atlas_rgb[a] = 0; atlas_room[a] = 0; atlas_cols[a] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corners();
    write_reg(REG_BORDER, 0);
    write_reg(REG_THRESH, 0);
    test_corners();
    test_random(350);
    write_reg(REG_BORDER, 15);
    write_reg(REG_THRESH, 1024);
    test_corners();
    test_random(300);
    calm = 1'b1;
    write_reg(REG_BORDER, 3);
    write_reg(REG_THRESH, 2047);
    test_random(300);
    calm = 1'b0;
    write_reg(REG_BORDER, $urandom_range(15));
    write_reg(REG_THRESH, $urandom_range(64));
    test_backpressure();
    test_random(350);
    if (!failed)
      $display("PASS glyph_atlas_column_allocator");
    else
      $display("FAIL glyph_atlas_column_allocator");
    $finish;
  end
endmodule

@@ files.f @@
rtl/gaca_pkg.sv
rtl/gaca_cell.sv
rtl/gaca_ctrl.sv
rtl/glyph_atlas_column_allocator.sv
tb/tb_glyph_atlas_column_allocator.sv
